[rtl/sorls_pkg.sv]
// Package: shared types, constants and fixed-point helpers of the steering offset estimator.
`timescale 1ns / 1ps
`default_nettype none
package sorls_pkg;

    localparam int unsigned QFRAC = 16;
    localparam logic [16:0] LAMBDA_ONE = 17'd65536;
    localparam logic [30:0] COV_RESET = 31'd65536000;
    localparam logic [16:0] FORGET_RESET = 17'd65470;
    localparam logic [20:0] WBASE_RESET = 21'd182845;
    localparam logic [30:0] MIN_SPEED_RESET = 31'd327680;
    localparam logic [30:0] MAX_STEER_RESET = 31'd3277;
    localparam logic [30:0] WARN_RESET = 31'd2860;
    localparam logic [30:0] PREP_LIMIT = 31'd65;
    localparam int unsigned DIV_STEPS = 64;
    localparam int unsigned ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_INIT_COV  = 3'd0,
        REG_FORGET    = 3'd1,
        REG_WBASE     = 3'd2,
        REG_MIN_SPEED = 3'd3,
        REG_MAX_STEER = 3'd4,
        REG_WARN      = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        DIAG_PREPARING = 2'd0,
        DIAG_OK        = 2'd1,
        DIAG_WARN      = 2'd2
    } t_diag;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIV_PHI,
        ST_PHI,
        ST_MUL_PHI2,
        ST_PHI2,
        ST_MUL_P,
        ST_DEN1,
        ST_DIV_PN,
        ST_PN,
        ST_MUL_PPN,
        ST_MUL_PNPHI,
        ST_DEN2,
        ST_DIV_K,
        ST_K,
        ST_MEAS,
        ST_ERR,
        ST_MUL_KE,
        ST_UPD,
        ST_OUT
    } t_state;

    // Clamp a 48-bit signed value to the signed 32-bit range.
    function automatic logic signed [31:0] f_sat48(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sh0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
        else if (v < -48'sh0000_8000_0000) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    // Clamp a 33-bit signed sum to the signed 32-bit range.
    function automatic logic signed [31:0] f_sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else r = v[31:0];
        return r;
    endfunction

    // Q16.16 product scaling: truncate toward zero, then saturate.
    function automatic logic signed [31:0] f_qmul(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + (p[63] ? 64'sd65535 : 64'sd0);
        return f_sat48(t[63:QFRAC]);
    endfunction

endpackage
`default_nettype wire

[rtl/steer_offset_rls_estimator_top.sv]
// Top level: steering offset estimator, scalar RLS with forgetting on a shared multiplier/divider.
`timescale 1ns / 1ps
`default_nettype none
// One word in, one word out per tick. A tick that lacks samples, runs below the
// minimum speed or steers beyond the maximum angle goes straight to the output
// state and reports state unchanged. An updating tick runs three 64-step
// restoring divisions (phi, new covariance, gain) on one shared 1-bit-per-cycle
// divider plus seven products on one shared registered 32x32 multiplier. The
// result word is loaded once the output state finds the output register free,
// and the input is then taken again in the idle state. o_stall stays high for the
// whole tick. A finished word sits in an output register, so the next tick is
// taken even while the consumer stalls the previous result. Configuration
// registers sit on an APB-style port at byte addresses 0, 4, ... 20; writing
// the start covariance register also reloads the covariance state. Write
// configuration only while no tick is in flight.
module steer_offset_rls_estimator_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // input channel
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire signed [31:0]            i_speed,
    input  wire signed [31:0]            i_yaw_rate,
    input  wire signed [31:0]            i_steer_angle,
    input  wire                          i_samples_present,
    // result channel
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic                         o_updated,
    output logic signed [31:0]           o_offset_estimate,
    output logic [30:0]                  o_covariance_now,
    output logic [1:0]                   o_diag_status,
    // configuration port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [sorls_pkg::ADDR_W-1:0]  paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    sorls_pkg::t_state r_state, n_state;

    // configuration registers
    logic [30:0] r_init_cov;
    logic [16:0] r_forget;
    logic [20:0] r_wbase;
    logic [30:0] r_min_speed;
    logic [30:0] r_max_steer;
    logic [30:0] r_warn;

    // estimator state
    logic signed [31:0] r_x;
    logic [30:0]        r_p;

    // latched tick and intermediates
    logic signed [31:0] r_wz, r_st;
    logic signed [31:0] r_phi, r_phi2, r_coef, r_meas, r_err;
    logic [30:0]        r_pn;
    logic [31:0]        r_den;
    logic               r_upd;

    // shared divider
    logic [63:0] r_num;
    logic [31:0] r_rem;
    logic [31:0] r_dden;
    logic        r_neg;
    logic [5:0]  r_cnt;

    // shared multiplier
    logic signed [63:0] r_prod;

    // output register
    logic               r_out_valid;
    logic               r_out_upd;
    logic signed [31:0] r_out_x;
    logic [30:0]        r_out_p;
    logic [1:0]         r_out_diag;

    logic cfg_wr;
    logic in_acc;
    logic out_free;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign o_stall  = (r_state != sorls_pkg::ST_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    // effective forgetting factor and wheel base
    logic [16:0] lam;
    logic [20:0] wb_eff;
    always_comb begin
        if (r_forget == 17'd0) lam = 17'd1;
        else if (r_forget > sorls_pkg::LAMBDA_ONE) lam = sorls_pkg::LAMBDA_ONE;
        else lam = r_forget;
        wb_eff = (r_wbase == 21'd0) ? 21'd1 : r_wbase;
    end

    // gating of the incoming tick
    logic [31:0] spd_mag, st_mag;
    logic        tick_ok;
    always_comb begin
        spd_mag = i_speed[31] ? (32'd0 - i_speed) : i_speed;
        st_mag  = i_steer_angle[31] ? (32'd0 - i_steer_angle) : i_steer_angle;
        tick_ok = i_samples_present && (spd_mag >= {1'b0, r_min_speed})
                  && (st_mag <= {1'b0, r_max_steer});
    end

    // configuration writes and reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_cov  <= sorls_pkg::COV_RESET;
            r_forget    <= sorls_pkg::FORGET_RESET;
            r_wbase     <= sorls_pkg::WBASE_RESET;
            r_min_speed <= sorls_pkg::MIN_SPEED_RESET;
            r_max_steer <= sorls_pkg::MAX_STEER_RESET;
            r_warn      <= sorls_pkg::WARN_RESET;
        end else if (cfg_wr) begin
            unique case (sorls_pkg::t_reg_idx'(paddr[4:2]))
                sorls_pkg::REG_INIT_COV:  r_init_cov  <= pwdata[30:0];
                sorls_pkg::REG_FORGET:    r_forget    <= pwdata[16:0];
                sorls_pkg::REG_WBASE:     r_wbase     <= pwdata[20:0];
                sorls_pkg::REG_MIN_SPEED: r_min_speed <= pwdata[30:0];
                sorls_pkg::REG_MAX_STEER: r_max_steer <= pwdata[30:0];
                sorls_pkg::REG_WARN:      r_warn      <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sorls_pkg::t_reg_idx'(paddr[4:2]))
            sorls_pkg::REG_INIT_COV:  prdata = {1'b0, r_init_cov};
            sorls_pkg::REG_FORGET:    prdata = {15'd0, r_forget};
            sorls_pkg::REG_WBASE:     prdata = {11'd0, r_wbase};
            sorls_pkg::REG_MIN_SPEED: prdata = {1'b0, r_min_speed};
            sorls_pkg::REG_MAX_STEER: prdata = {1'b0, r_max_steer};
            sorls_pkg::REG_WARN:      prdata = {1'b0, r_warn};
            default:                  prdata = 32'd0;
        endcase
    end

    // saturated divider result: quotient magnitude in r_num, sign in r_neg
    logic signed [31:0] div_sat;
    always_comb begin
        if (r_neg) begin
            if ((|r_num[63:32]) || (r_num[31] && (|r_num[30:0]))) div_sat = 32'sh8000_0000;
            else div_sat = 32'sd0 - $signed(r_num[31:0]);
        end else begin
            if (|r_num[63:31]) div_sat = 32'sh7FFF_FFFF;
            else div_sat = $signed(r_num[31:0]);
        end
    end

    logic signed [31:0] prod_q;
    assign prod_q = sorls_pkg::f_qmul(r_prod);

    logic [63:0] prod_mag;
    assign prod_mag = r_prod[63] ? (64'd0 - r_prod) : r_prod;

    // sequencer: next state, multiplier operands and divider loads
    logic               mul_en;
    logic signed [31:0] mul_a, mul_b;
    logic               div_load;
    logic [63:0]        div_num;
    logic [31:0]        div_den;
    logic               div_neg;
    logic               div_step;
    logic               div_last;
    assign div_last = (r_cnt == 6'(sorls_pkg::DIV_STEPS - 1));

    always_comb begin
        n_state  = r_state;
        mul_en   = 1'b0;
        mul_a    = r_phi;
        mul_b    = r_phi;
        div_load = 1'b0;
        div_num  = 64'd0;
        div_den  = 32'd1;
        div_neg  = 1'b0;
        div_step = 1'b0;
        unique case (r_state)
            sorls_pkg::ST_IDLE: begin
                if (in_acc) begin
                    div_load = 1'b1;
                    div_num  = {16'd0, spd_mag, 16'd0};
                    div_den  = {11'd0, wb_eff};
                    div_neg  = i_speed[31];
                    n_state  = tick_ok ? sorls_pkg::ST_DIV_PHI : sorls_pkg::ST_OUT;
                end
            end
            sorls_pkg::ST_DIV_PHI: begin
                div_step = 1'b1;
                if (div_last) n_state = sorls_pkg::ST_PHI;
            end
            sorls_pkg::ST_PHI:      n_state = sorls_pkg::ST_MUL_PHI2;
            sorls_pkg::ST_MUL_PHI2: begin
                mul_en  = 1'b1;
                n_state = sorls_pkg::ST_PHI2;
            end
            sorls_pkg::ST_PHI2:     n_state = sorls_pkg::ST_MUL_P;
            sorls_pkg::ST_MUL_P: begin
                mul_en  = 1'b1;
                mul_a   = r_phi2;
                mul_b   = $signed({1'b0, r_p});
                n_state = sorls_pkg::ST_DEN1;
            end
            sorls_pkg::ST_DEN1: begin
                div_load = 1'b1;
                div_num  = {17'd0, r_p, 16'd0};
                div_den  = {15'd0, lam} + {1'b0, prod_q[30:0]};
                n_state  = sorls_pkg::ST_DIV_PN;
            end
            sorls_pkg::ST_DIV_PN: begin
                div_step = 1'b1;
                if (div_last) n_state = sorls_pkg::ST_PN;
            end
            sorls_pkg::ST_PN:       n_state = sorls_pkg::ST_MUL_PPN;
            sorls_pkg::ST_MUL_PPN: begin
                mul_en  = 1'b1;
                mul_a   = r_phi2;
                mul_b   = $signed({1'b0, r_pn});
                n_state = sorls_pkg::ST_MUL_PNPHI;
            end
            sorls_pkg::ST_MUL_PNPHI: begin
                mul_en  = 1'b1;
                mul_a   = $signed({1'b0, r_pn});
                mul_b   = r_phi;
                n_state = sorls_pkg::ST_DEN2;
            end
            sorls_pkg::ST_DEN2: begin
                div_load = 1'b1;
                div_num  = prod_mag;
                div_den  = r_den;
                div_neg  = r_prod[63];
                n_state  = sorls_pkg::ST_DIV_K;
            end
            sorls_pkg::ST_DIV_K: begin
                div_step = 1'b1;
                if (div_last) n_state = sorls_pkg::ST_K;
            end
            sorls_pkg::ST_K: begin
                mul_en  = 1'b1;
                mul_a   = r_phi;
                mul_b   = r_st;
                n_state = sorls_pkg::ST_MEAS;
            end
            sorls_pkg::ST_MEAS: begin
                mul_en  = 1'b1;
                mul_a   = r_phi;
                mul_b   = r_x;
                n_state = sorls_pkg::ST_ERR;
            end
            sorls_pkg::ST_ERR:      n_state = sorls_pkg::ST_MUL_KE;
            sorls_pkg::ST_MUL_KE: begin
                mul_en  = 1'b1;
                mul_a   = r_coef;
                mul_b   = r_err;
                n_state = sorls_pkg::ST_UPD;
            end
            sorls_pkg::ST_UPD:      n_state = sorls_pkg::ST_OUT;
            sorls_pkg::ST_OUT: begin
                if (out_free) n_state = sorls_pkg::ST_IDLE;
            end
            default:                n_state = sorls_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= sorls_pkg::ST_IDLE;
        else r_state <= n_state;
    end

    // shared multiplier, registered product
    always_ff @(posedge i_clk) begin
        if (mul_en) r_prod <= mul_a * mul_b;
    end

    // shared restoring divider: one quotient bit per cycle
    logic [32:0] div_sh;
    logic        div_ge;
    assign div_sh = {r_rem, r_num[63]};
    assign div_ge = (div_sh >= {1'b0, r_dden});

    always_ff @(posedge i_clk) begin
        if (div_load) begin
            r_num  <= div_num;
            r_rem  <= 32'd0;
            r_dden <= div_den;
            r_neg  <= div_neg;
            r_cnt  <= 6'd0;
        end else if (div_step) begin
            r_rem  <= div_ge ? 32'(div_sh - {1'b0, r_dden}) : div_sh[31:0];
            r_num  <= {r_num[62:0], div_ge};
            r_cnt  <= r_cnt + 6'd1;
        end
    end

    // datapath registers, advanced by the sequencer
    always_ff @(posedge i_clk) begin
        case (r_state)
            sorls_pkg::ST_IDLE: begin
                if (in_acc) begin
                    r_wz  <= i_yaw_rate;
                    r_st  <= i_steer_angle;
                    r_upd <= tick_ok;
                end
            end
            sorls_pkg::ST_PHI:       r_phi  <= div_sat;
            sorls_pkg::ST_PHI2:      r_phi2 <= prod_q;
            sorls_pkg::ST_PN:        r_pn   <= div_sat[30:0];
            sorls_pkg::ST_MUL_PNPHI: r_den  <= {15'd0, lam} + {1'b0, prod_q[30:0]};
            sorls_pkg::ST_K:         r_coef <= div_sat;
            sorls_pkg::ST_MEAS:
                r_meas <= sorls_pkg::f_sat33({r_wz[31], r_wz} - {prod_q[31], prod_q});
            sorls_pkg::ST_ERR:
                r_err <= sorls_pkg::f_sat33({r_meas[31], r_meas} - {prod_q[31], prod_q});
            default: ;
        endcase
    end

    // estimator state; a covariance register write reloads P
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= 32'sd0;
            r_p <= sorls_pkg::COV_RESET;
        end else if (cfg_wr && (sorls_pkg::t_reg_idx'(paddr[4:2]) == sorls_pkg::REG_INIT_COV)) begin
            r_p <= pwdata[30:0];
        end else if (r_state == sorls_pkg::ST_UPD) begin
            r_x <= sorls_pkg::f_sat33({r_x[31], r_x} + {prod_q[31], prod_q});
            r_p <= r_pn;
        end
    end

    // diagnostic status from the state after this tick
    logic [31:0]      x_mag;
    sorls_pkg::t_diag diag;
    always_comb begin
        x_mag = r_x[31] ? (32'd0 - r_x) : r_x;
        if (r_p > sorls_pkg::PREP_LIMIT) diag = sorls_pkg::DIAG_PREPARING;
        else if (x_mag > {1'b0, r_warn}) diag = sorls_pkg::DIAG_WARN;
        else diag = sorls_pkg::DIAG_OK;
    end

    // output register: hold while stalled, load the finished word when free
    logic out_load;
    assign out_load = (r_state == sorls_pkg::ST_OUT) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_upd  <= r_upd;
            r_out_x    <= r_x;
            r_out_p    <= r_p;
            r_out_diag <= diag;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_updated         = r_out_upd;
    assign o_offset_estimate = r_out_x;
    assign o_covariance_now  = r_out_p;
    assign o_diag_status     = r_out_diag;

endmodule
`default_nettype wire

[rtl/sorls_checker.sv]
// Checker: port-level properties of the steering offset estimator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sorls_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_valid,
    input wire               o_stall,
    input wire               o_valid,
    input wire               i_stall,
    input wire signed [31:0] o_offset_estimate,
    input wire [30:0]        o_covariance_now,
    input wire [1:0]         o_diag_status
);

    // a taken word keeps the input side busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input side not busy after an accepted word");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_offset_estimate)
                                  && $stable(o_covariance_now)))
        else $error("stalled result changed");

    // preparing status exactly when covariance is above the limit
    a_diag_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_diag_status == sorls_pkg::DIAG_PREPARING)
                     == (o_covariance_now > sorls_pkg::PREP_LIMIT)))
        else $error("diagnostic status disagrees with covariance");

    // only defined status codes
    a_diag_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_diag_status == sorls_pkg::DIAG_PREPARING)
                     || (o_diag_status == sorls_pkg::DIAG_OK)
                     || (o_diag_status == sorls_pkg::DIAG_WARN)))
        else $error("invalid diagnostic status code");

endmodule

bind steer_offset_rls_estimator_top sorls_checker u_sorls_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_offset_estimate (o_offset_estimate),
    .o_covariance_now  (o_covariance_now),
    .o_diag_status     (o_diag_status)
);
`default_nettype wire
